// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is active.
`define PDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define PDC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types, constants and the CRC-32 byte step for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

  localparam int unsigned LEN_W    = 45;
  localparam int unsigned CNT_W    = 46;
  localparam int unsigned HDR_W    = 64;
  localparam int unsigned CRC_W    = 32;
  localparam int unsigned LINE_LEN = 4;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = LEN_W'(65535);
  localparam logic [CNT_W-1:0] MIN_LENGTH = CNT_W'(12);
  localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(8);
  localparam logic [CNT_W-1:0] LINE_BYTES = CNT_W'(LINE_LEN);

  // Queue between the front and back halves.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // APB register map: one 64-bit register slot per 8 bytes.
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned PDATA_W = 64;
  localparam logic REG_MAX_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUF_SHORT = 3'd1,
    ST_LEN_SMALL = 3'd2,
    ST_LEN_LARGE = 3'd3,
    ST_SIZE_MISM = 3'd4,
    ST_CRC_BAD   = 3'd5
  } pdc_status_t;

  // One classified input byte, as handed from the front to the back.
  typedef struct packed {
    logic [7:0]       leaving;
    logic             crc_upd;
    logic             emit;
    logic             fin;
    logic [HDR_W-1:0] header;
    logic [CRC_W-1:0] rx_crc;
    logic             short_buf;
    logic             len_small;
    logic             len_large;
    logic             size_mism;
  } pdc_entry_t;

  // One result item.
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             is_status;
    logic             end_of_run;
    pdc_status_t      status;
    logic [3:0]       version;
    logic [LEN_W-1:0] packet_length;
    logic             fragment;
    logic [3:0]       payload_kind;
    logic [9:0]       user_value;
    logic [CRC_W-1:0] received_crc;
    logic [CRC_W-1:0] computed_crc;
  } pdc_result_t;

  // Reflected CRC-32, one byte.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/pdc_front.sv =====
// ----------------------------------------------------------------------------
// pdc_front
// Byte intake: delay line, header capture, byte count and length checks.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [7:0]                   byte_in,
  input  wire logic                         final_byte,
  input  wire logic [pdc_pkg::LEN_W-1:0]    max_length,
  output pdc_pkg::pdc_entry_t               entry
);

  logic [pdc_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [pdc_pkg::HDR_W-1:0] hdr_r, hdr_nxt, hdr_upd;
  logic [7:0]                dly_r   [pdc_pkg::LINE_LEN];
  logic [7:0]                dly_nxt [pdc_pkg::LINE_LEN];
  logic [pdc_pkg::LEN_W-1:0] len;

  always_comb begin
    hdr_upd = hdr_r;
    if (cnt_r < pdc_pkg::HDR_BYTES) begin
      hdr_upd = hdr_r | (pdc_pkg::HDR_W'(byte_in) << {cnt_r[2:0], 3'b000});
    end
    cnt_inc = (cnt_r != pdc_pkg::COUNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    len     = hdr_upd[48:4];

    entry.leaving   = dly_r[0];
    entry.crc_upd   = (cnt_r >= pdc_pkg::LINE_BYTES);
    entry.emit      = (cnt_r >= pdc_pkg::MIN_LENGTH);
    entry.fin       = final_byte;
    entry.header    = hdr_upd;
    entry.rx_crc    = {byte_in, dly_r[3], dly_r[2], dly_r[1]};
    entry.short_buf = (cnt_inc < pdc_pkg::MIN_LENGTH);
    entry.len_small = ({1'b0, len} < pdc_pkg::MIN_LENGTH);
    entry.len_large = (len > max_length);
    entry.size_mism = (cnt_inc != {1'b0, len});

    // A final byte closes the packet: back to the reset picture.
    if (final_byte) begin
      cnt_nxt = '0;
      hdr_nxt = '0;
      for (int i = 0; i < pdc_pkg::LINE_LEN; i++) dly_nxt[i] = '0;
    end else begin
      cnt_nxt = cnt_inc;
      hdr_nxt = hdr_upd;
      for (int i = 0; i < pdc_pkg::LINE_LEN - 1; i++) dly_nxt[i] = dly_r[i+1];
      dly_nxt[pdc_pkg::LINE_LEN-1] = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hdr_r <= '0;
      for (int i = 0; i < pdc_pkg::LINE_LEN; i++) dly_r[i] <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      hdr_r <= hdr_nxt;
      for (int i = 0; i < pdc_pkg::LINE_LEN; i++) dly_r[i] <= dly_nxt[i];
    end
  end

endmodule

`default_nettype wire

// ===== src/pdc_queue.sv =====
// ----------------------------------------------------------------------------
// pdc_queue
// Short FIFO of classified bytes between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire pdc_pkg::pdc_entry_t wr_data,
  input  wire logic                rd_en,
  output pdc_pkg::pdc_entry_t      rd_data,
  output logic                     full,
  output logic                     not_empty
);

  pdc_pkg::pdc_entry_t         mem_r [pdc_pkg::QUEUE_DEPTH];
  logic [pdc_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pdc_pkg::QPTR_W:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == (pdc_pkg::QPTR_W+1)'(pdc_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== src/pdc_back.sv =====
// ----------------------------------------------------------------------------
// pdc_back
// Running CRC, status resolution and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire pdc_pkg::pdc_entry_t head,
  output logic                     q_pop,
  input  wire logic                out_take,
  output logic                     out_valid,
  output pdc_pkg::pdc_result_t     out_item
);

  logic                       phase_r, phase_nxt;   // payload of a final entry sent
  logic [pdc_pkg::CRC_W-1:0]  crc_r, crc_nxt, crc_step, crc_eff, cc;
  logic                       out_valid_r, out_valid_nxt;
  pdc_pkg::pdc_result_t       item_r, item_nxt;
  logic                       silent, room, load, gen_payload;
  pdc_pkg::pdc_status_t       st;

  assign out_valid = out_valid_r;
  assign out_item  = item_r;

  always_comb begin
    crc_step    = head.crc_upd ? pdc_pkg::crc_byte(crc_r, head.leaving) : crc_r;
    crc_eff     = phase_r ? crc_r : crc_step;
    cc          = ~crc_eff;
    silent      = !head.emit && !head.fin;
    room        = !out_valid_r || out_take;
    gen_payload = head.emit && !phase_r;
    load        = q_valid && !silent && room;

    priority if (head.short_buf) st = pdc_pkg::ST_BUF_SHORT;
    else if (head.len_small)     st = pdc_pkg::ST_LEN_SMALL;
    else if (head.len_large)     st = pdc_pkg::ST_LEN_LARGE;
    else if (head.size_mism)     st = pdc_pkg::ST_SIZE_MISM;
    else if (cc != head.rx_crc)  st = pdc_pkg::ST_CRC_BAD;
    else                         st = pdc_pkg::ST_OK;

    q_pop         = 1'b0;
    crc_nxt       = crc_r;
    phase_nxt     = phase_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    if (out_take) out_valid_nxt = 1'b0;

    if (q_valid && silent) begin
      q_pop   = 1'b1;
      crc_nxt = crc_step;
    end else if (load) begin
      out_valid_nxt = 1'b1;
      item_nxt      = '0;
      if (gen_payload) begin
        item_nxt.payload_byte = head.leaving;
        item_nxt.end_of_run   = !head.fin;
        crc_nxt               = crc_step;
        if (head.fin) begin
          phase_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        item_nxt.is_status     = 1'b1;
        item_nxt.end_of_run    = 1'b1;
        item_nxt.status        = st;
        item_nxt.version       = head.header[3:0];
        item_nxt.packet_length = head.header[48:4];
        item_nxt.fragment      = head.header[49];
        item_nxt.payload_kind  = head.header[53:50];
        item_nxt.user_value    = head.header[63:54];
        item_nxt.received_crc  = head.rx_crc;
        item_nxt.computed_crc  = cc;
        crc_nxt                = pdc_pkg::CRC_INIT;
        phase_nxt              = 1'b0;
        q_pop                  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      crc_r       <= pdc_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

// ===== src/packet_deframer_crc32_check.sv =====
// ----------------------------------------------------------------------------
// packet_deframer_crc32_check
// Byte-stream packet deframer: strips an 8-byte header and 4-byte CRC-32
// trailer, streams payload bytes, and closes each packet with a status item.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | in_byte_in, in_final_byte
//  result   | pop / empty        | out_payload_byte ... out_computed_crc
//  config   | APB psel/penable   | max_length at paddr 0 (64-bit data)
//
//  Up to one byte per cycle while full is low: each accepted byte passes the
//  combinational front, sits in a 4-entry queue, and the back turns it into
//  at most one result per cycle. A final byte that also releases a payload
//  byte makes the back give two results (payload, then status).
//  A pushed byte passes the queue and the registered result stage on its way
//  to the ports. Synchronous active-low reset clears counters and all valid
//  flags and presets the CRC; no clearing pass is needed.
//  A stalled result side fills the queue and then raises full.
//
`default_nettype none

module packet_deframer_crc32_check (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    in_byte_in,
  input  wire logic                          in_final_byte,
  // result channel
  output logic                               empty,
  input  wire logic                          pop,
  output logic [7:0]                         out_payload_byte,
  output logic                               out_is_status,
  output logic                               out_end_of_run,
  output logic [2:0]                         out_status,
  output logic [3:0]                         out_version,
  output logic [pdc_pkg::LEN_W-1:0]          out_packet_length,
  output logic                               out_fragment,
  output logic [3:0]                         out_payload_kind,
  output logic [9:0]                         out_user_value,
  output logic [pdc_pkg::CRC_W-1:0]          out_received_crc,
  output logic [pdc_pkg::CRC_W-1:0]          out_computed_crc,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pdc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pdc_pkg::PDATA_W-1:0]   pwdata,
  output logic [pdc_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  // Register file: only max_length; addresses decode on the 8-byte slot.
  logic [pdc_pkg::LEN_W-1:0] max_length_r;
  logic                      cfg_wr, reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[3] == pdc_pkg::REG_MAX_LENGTH);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? pdc_pkg::PDATA_W'(max_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= pdc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_wr) begin
      max_length_r <= pwdata[pdc_pkg::LEN_W-1:0];
    end
  end

  // Front -> queue -> back
  pdc_pkg::pdc_entry_t  fr_entry, q_head;
  pdc_pkg::pdc_result_t item;
  logic                 accept, q_full, q_valid, q_pop, out_valid, out_take;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign empty    = !out_valid;
  assign out_take = pop && out_valid;

  pdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_in    (in_byte_in),
    .final_byte (in_final_byte),
    .max_length (max_length_r),
    .entry      (fr_entry)
  );

  pdc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_data   (fr_entry),
    .rd_en     (q_pop),
    .rd_data   (q_head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  pdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_take  (out_take),
    .out_valid (out_valid),
    .out_item  (item)
  );

  assign out_payload_byte  = item.payload_byte;
  assign out_is_status     = item.is_status;
  assign out_end_of_run    = item.end_of_run;
  assign out_status        = item.status;
  assign out_version       = item.version;
  assign out_packet_length = item.packet_length;
  assign out_fragment      = item.fragment;
  assign out_payload_kind  = item.payload_kind;
  assign out_user_value    = item.user_value;
  assign out_received_crc  = item.received_crc;
  assign out_computed_crc  = item.computed_crc;

endmodule

`default_nettype wire

// ===== src/pdc_checker.sv =====
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pdc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [7:0]                  out_payload_byte,
  input wire logic                        out_is_status,
  input wire logic                        out_end_of_run,
  input wire logic [2:0]                  out_status,
  input wire logic [pdc_pkg::CRC_W-1:0]   out_computed_crc
);

  // Nothing is offered in the cycle after reset.
  `PDC_ASSERT_RST(a_empty_after_rst, !rst_n |=> empty, "result offered right after reset")

  // A status transaction always closes the run of its input byte.
  `PDC_ASSERT(a_status_ends_run, (!empty && out_is_status) |-> out_end_of_run, "status without end_of_run")

  // Payload transactions carry no status or CRC information.
  `PDC_ASSERT(a_payload_clean, (!empty && !out_is_status) |-> (out_status == 3'd0 && out_computed_crc == '0), "payload carries status fields")

  // A stalled transaction holds its byte.
  `PDC_ASSERT(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(out_payload_byte)), "stalled result changed")

  // Status codes stay within the defined set.
  `PDC_ASSERT(a_status_range, !empty |-> (out_status <= 3'd5), "undefined status code")

endmodule

bind packet_deframer_crc32_check pdc_checker u_pdc_checker (.*);

`default_nettype wire
